// File: design/hbt_pkg.sv
// Shared types and constants for the handshake bit transmitter.
// Holds buffer sizing, request modes and the transfer phase encoding.
// No dependencies.
`timescale 1ns / 1ps

package hbt_pkg;

  // Bit buffer sizing
  localparam int CAPACITY_BITS = 16384;
  localparam int PTR_W         = $clog2(CAPACITY_BITS + 1);
  localparam int NUM_BANKS     = 8;
  localparam int BANK_DEPTH    = (CAPACITY_BITS + NUM_BANKS - 1) / NUM_BANKS;
  localparam int BANK_AW       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int BYTE_BITS     = 8;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [BANK_AW-1:0] bank_addr_t;

  // Request modes
  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_PUSH_BIT  = 2'd1,
    MODE_PUSH_BYTE = 2'd2,
    MODE_FLUSH     = 2'd3
  } mode_t;

  // Transfer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PRESENT = 4'b0010,
    PH_STROBE  = 4'b0100,
    PH_RETIRE  = 4'b1000
  } phase_t;

endpackage

// File: design/handshake_bit_transmitter.sv
// Results are registered: each appears the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the bit store is split into
// eight one-bit banks so a byte push writes up to eight bits while the head bit
// is read. It is prefetched every cycle at the next read pointer, with a
// bypass for a write to the same entry. Reset idles phase, pointers and lines;
// the store is never cleared, since entries are read only after being written.
`timescale 1ns / 1ps

module handshake_bit_transmitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hbt_pkg::mode_t    in_mode,
  input  logic              in_rd_level,
  input  logic              in_id_level,
  input  logic [7:0]        in_data_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_tx_level,
  output logic              out_ta_level,
  output logic              out_ia_level,
  output logic              out_push_status,
  output logic              out_all_sent
);

  import hbt_pkg::*;

  localparam ptr_t CAP_PTR = PTR_W'(CAPACITY_BITS);
  localparam ptr_t BYTE_PTR = PTR_W'(BYTE_BITS);

  // State registers
  phase_t phase_r, phase_nxt;
  ptr_t   rp_r, rp_nxt;
  ptr_t   wp_r, wp_nxt;
  logic   tx_r, tx_nxt;
  logic   ta_r, ta_nxt;
  logic   ia_r, ia_nxt;
  logic   status_r, status_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Head-bit bypass
  logic   byp_hit_r, byp_hit_nxt;
  logic   byp_bit_r, byp_bit_nxt;

  logic       in_acc;
  logic       go;
  logic       head_bit;
  ptr_t       space;
  logic [3:0] wr_cnt;
  logic [2:0] rd_bank;
  bank_addr_t rd_addr;

  logic       bank_we    [NUM_BANKS];
  bank_addr_t bank_waddr [NUM_BANKS];
  logic       bank_wbit  [NUM_BANKS];
  logic       bank_rdata [NUM_BANKS];

  // Handshake: accept whenever the output register is free or being drained
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign out_tx_level     = tx_r;
  assign out_ta_level     = ta_r;
  assign out_ia_level     = ia_r;
  assign out_push_status  = status_r;
  assign out_all_sent     = (wp_r <= rp_r);

  // Head bit: store[rp_r], from the bank or from a write that raced the read
  assign head_bit = byp_hit_r ? byp_bit_r : bank_rdata[rp_r[2:0]];

  assign go    = !in_rd_level && in_id_level && (wp_r > rp_r);
  assign space = CAP_PTR - wp_r;

  // Request decode and next state
  always_comb begin
    phase_nxt     = phase_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    tx_nxt        = tx_r;
    ta_nxt        = ta_r;
    ia_nxt        = ia_r;
    status_nxt    = status_r;
    wr_cnt        = 4'd0;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = 1'b0;
      case (in_mode)
        MODE_TICK: begin
          case (phase_r)
            PH_IDLE: begin
              ia_nxt = 1'b1;
              if (go) begin
                phase_nxt = PH_PRESENT;
              end
            end
            PH_PRESENT: begin
              ta_nxt = 1'b0;
              tx_nxt = 1'b0;
              if (go) begin
                ia_nxt    = 1'b0;
                tx_nxt    = head_bit;
                phase_nxt = PH_STROBE;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_STROBE: begin
              ta_nxt = 1'b1;
              if (in_rd_level || in_id_level) begin
                phase_nxt = PH_RETIRE;
              end
            end
            default: begin
              if (rp_r < CAP_PTR) begin
                rp_nxt = rp_r + PTR_W'(1);
              end
              ta_nxt    = 1'b0;
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        MODE_PUSH_BIT: begin
          if (wp_r < CAP_PTR) begin
            wr_cnt = 4'd1;
          end else begin
            status_nxt = 1'b1;
          end
          wp_nxt = wp_r + PTR_W'(wr_cnt);
        end
        MODE_PUSH_BYTE: begin
          if (space >= BYTE_PTR) begin
            wr_cnt = 4'd8;
          end else begin
            wr_cnt     = space[3:0];
            status_nxt = 1'b1;
          end
          wp_nxt = wp_r + PTR_W'(wr_cnt);
        end
        MODE_FLUSH: begin
          rp_nxt = '0;
          wp_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Bank write ports: bit j of a push lands in bank (wp + j) mod 8
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      logic [2:0] j;
      ptr_t       widx;
      j             = 3'(b) - wp_r[2:0];
      widx          = wp_r + PTR_W'(j);
      bank_we[b]    = ({1'b0, j} < wr_cnt);
      bank_waddr[b] = BANK_AW'(widx >> 3);
      bank_wbit[b]  = (in_mode == MODE_PUSH_BIT) ? in_data_value[0] : in_data_value[j];
    end
  end

  // Prefetch read at the next read pointer, with same-entry bypass
  assign rd_bank     = rp_nxt[2:0];
  assign rd_addr     = BANK_AW'(rp_nxt >> 3);
  assign byp_hit_nxt = bank_we[rd_bank] && (bank_waddr[rd_bank] == rd_addr);
  assign byp_bit_nxt = bank_wbit[rd_bank];

  // Bit store banks
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    hbt_ram #(
      .WIDTH (1),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wbit[g]),
      .raddr (rd_addr),
      .rdata (bank_rdata[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      tx_r        <= 1'b0;
      ta_r        <= 1'b0;
      ia_r        <= 1'b1;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      tx_r        <= tx_nxt;
      ta_r        <= ta_nxt;
      ia_r        <= ia_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Bypass registers, no reset needed
  always_ff @(posedge clk) begin
    byp_hit_r <= byp_hit_nxt;
    byp_bit_r <= byp_bit_nxt;
  end

  // Checks
  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= CAP_PTR)
    else $error("write pointer beyond capacity");

  a_strobe_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STROBE || phase_r == PH_RETIRE) |-> !ia_r)
    else $error("idle line high during a transfer");

  a_drop_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (wp_r == CAP_PTR))
    else $error("push dropped bits while space remained");

  a_retire_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_TICK && phase_r == PH_RETIRE)
      |=> (phase_r == PH_IDLE && !ta_r))
    else $error("retire did not return to idle with strobe low");

  a_bit_push_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_PUSH_BIT && wp_r < CAP_PTR)
      |=> (wp_r == $past(wp_r) + PTR_W'(1)))
    else $error("accepted bit push did not advance write pointer");

endmodule

// File: design/hbt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old data.
// No dependencies.
`timescale 1ns / 1ps

module hbt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sim/tb_handshake_bit_transmitter.sv
// Testbench for handshake_bit_transmitter: random and directed requests with a
// line-level predictor held in a small scoreboard class.
// Depends on design/hbt_pkg.sv and design/handshake_bit_transmitter.sv.
`timescale 1ns / 1ps

module tb_handshake_bit_transmitter;
  import hbt_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT = 26;

  typedef struct packed {
    logic tx_level;
    logic ta_level;
    logic ia_level;
    logic push_status;
    logic all_sent;
  } line_result_t;

  // Tracks transmitter state and the line levels each request should produce
  class line_scoreboard;
    bit           stored_bits [CAPACITY_BITS];
    int unsigned  rd_ptr;
    int unsigned  wr_ptr;
    phase_t       phase;
    logic         tx, ta, ia;
    line_result_t expected_lines [$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  bits_sent;
    int unsigned  drops;
    int unsigned  flushes;

    function new();
      rd_ptr    = 0;
      wr_ptr    = 0;
      phase     = PH_IDLE;
      tx        = 1'b0;
      ta        = 1'b0;
      ia        = 1'b1;
      errors    = 0;
      checked   = 0;
      bits_sent = 0;
      drops     = 0;
      flushes   = 0;
    endfunction

    // Returns 0 when the buffer is already full
    function bit store_bit(logic value);
      if (wr_ptr >= CAPACITY_BITS) return 1'b0;
      stored_bits[wr_ptr] = value;
      wr_ptr++;
      return 1'b1;
    endfunction

    function void note_request(mode_t mode, logic rd, logic id, logic [7:0] data);
      logic         go;
      logic         dropped;
      line_result_t res;
      dropped = 1'b0;
      case (mode)
        MODE_TICK: begin
          go = !rd && id && (wr_ptr > rd_ptr);
          case (phase)
            PH_IDLE: begin
              ia = 1'b1;
              if (go) phase = PH_PRESENT;
            end
            PH_PRESENT: begin
              ta = 1'b0;
              tx = 1'b0;
              if (!go) begin
                phase = PH_IDLE;
              end else begin
                ia    = 1'b0;
                tx    = stored_bits[rd_ptr];
                phase = PH_STROBE;
              end
            end
            PH_STROBE: begin
              ta = 1'b1;
              if (rd || id) phase = PH_RETIRE;
            end
            default: begin
              // retire ignores the pin levels
              if (rd_ptr < CAPACITY_BITS) rd_ptr++;
              ta    = 1'b0;
              phase = PH_IDLE;
              bits_sent++;
            end
          endcase
        end
        MODE_PUSH_BIT: dropped = !store_bit(data[0]);
        MODE_PUSH_BYTE: begin
          // lsb first; stop at the first bit that does not fit
          for (int i = 0; i < 8; i++) begin
            if (!dropped) dropped = !store_bit(data[i]);
          end
        end
        default: begin
          // flush rewinds pointers only; phase and lines stay
          rd_ptr = 0;
          wr_ptr = 0;
          flushes++;
        end
      endcase
      if (dropped) drops++;
      res.tx_level     = tx;
      res.ta_level     = ta;
      res.ia_level     = ia;
      res.push_status  = dropped;
      res.all_sent     = (wr_ptr <= rd_ptr);
      expected_lines.push_back(res);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (want !== got) begin
        $error("%s mismatch: expected %0b, actual %0b", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(line_result_t got);
      line_result_t want;
      if (expected_lines.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = expected_lines.pop_front();
      checked++;
      compare_bit("tx_level", want.tx_level, got.tx_level);
      compare_bit("ta_level", want.ta_level, got.ta_level);
      compare_bit("ia_level", want.ia_level, got.ia_level);
      compare_bit("push_status", want.push_status, got.push_status);
      compare_bit("all_sent", want.all_sent, got.all_sent);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  mode_t      in_mode;
  logic       in_rd_level;
  logic       in_id_level;
  logic [7:0] in_data_value;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_tx_level;
  logic       out_ta_level;
  logic       out_ia_level;
  logic       out_push_status;
  logic       out_all_sent;

  line_scoreboard line_sb;
  bit             steady_flow;
  int unsigned    requests_sent;
  int unsigned    stuck_cycles = 0;

  handshake_bit_transmitter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_rd_level      (in_rd_level),
    .in_id_level      (in_id_level),
    .in_data_value    (in_data_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_level     (out_tx_level),
    .out_ta_level     (out_ta_level),
    .out_ia_level     (out_ia_level),
    .out_push_status  (out_push_status),
    .out_all_sent     (out_all_sent)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check accepted results, stall at random outside steady flow
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      line_sb.check_result({out_tx_level, out_ta_level, out_ia_level,
                            out_push_status, out_all_sent});
    out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
  end

  // Count cycles where neither channel moves
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $error("no request or result moved for %0d cycles", STUCK_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Present one request, with optional idle cycles first, and wait for accept
  task automatic send_req(mode_t mode, logic rd, logic id, logic [7:0] data);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_rd_level   <= rd;
    in_id_level   <= id;
    in_data_value <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line_sb.note_request(mode, rd, id, data);
    requests_sent++;
  endtask

  // Hold off new requests until every expected result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_sb.expected_lines.size() != 0) @(posedge clk);
  endtask

  // One well-formed bit transfer: present, strobe hold, release, retire
  task automatic run_transfer();
    logic [1:0] release_lv;
    send_req(MODE_TICK, 1'b0, 1'b1, 8'($urandom));
    send_req(MODE_TICK, 1'b0, 1'b1, 8'($urandom));
    repeat ($urandom_range(0, 3)) send_req(MODE_TICK, 1'b0, 1'b0, 8'($urandom));
    release_lv = 2'($urandom_range(1, 3));
    send_req(MODE_TICK, release_lv[1], release_lv[0], 8'($urandom));
    send_req(MODE_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom));
  endtask

  // Mostly transfers and pushes, with noise ticks and rare flushes
  task automatic random_traffic(int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = requests_sent;
    while (requests_sent - start < count) begin
      steady_flow = (requests_sent - start >= 300) && (requests_sent - start < 450);
      pick = $urandom_range(99);
      if (pick < 35)
        run_transfer();
      else if (pick < 60)
        send_req(MODE_PUSH_BYTE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 8'($urandom));
      else if (pick < 75)
        send_req(MODE_PUSH_BIT, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 8'($urandom));
      else if (pick < 78)
        send_req(MODE_FLUSH, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 8'($urandom));
      else
        send_req(MODE_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 8'($urandom));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    line_sb       = new();
    steady_flow   = 1'b0;
    requests_sent = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_TICK;
    in_rd_level   = 1'b0;
    in_id_level   = 1'b0;
    in_data_value = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ticks, pushes at data extremes and a mixed byte
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b1, 1'b1, 8'hFF);
    send_req(MODE_PUSH_BIT, 1'b1, 1'b0, 8'hFE);
    send_req(MODE_PUSH_BYTE, 1'b0, 1'b0, 8'hFF);
    send_req(MODE_PUSH_BYTE, 1'b1, 1'b1, 8'h00);
    send_req(MODE_PUSH_BYTE, 1'b0, 1'b1, 8'hA5);
    // full transfer with a held strobe
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b0, 8'h00);
    send_req(MODE_TICK, 1'b1, 1'b0, 8'h00);
    send_req(MODE_TICK, 1'b1, 1'b1, 8'h00);
    // present aborted by the receiver
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b1, 1'b1, 8'h00);
    // flush in the middle of a transfer, retire past the write pointer
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_FLUSH, 1'b0, 1'b0, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b0, 8'h00);
    send_req(MODE_PUSH_BIT, 1'b0, 1'b0, 8'h01);
    send_req(MODE_PUSH_BIT, 1'b0, 1'b0, 8'h01);
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h00);
    send_req(MODE_TICK, 1'b0, 1'b1, 8'h80);
    send_req(MODE_TICK, 1'b0, 1'b0, 8'h7F);
    send_req(MODE_FLUSH, 1'b1, 1'b1, 8'hFF);
    wait_for_results();

    // Random transfers and pushes around a flush
    random_traffic(500);
    send_req(MODE_FLUSH, 1'b0, 1'b0, 8'h00);
    random_traffic(500);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_sb.expected_lines.size() != 0) begin
      $error("%0d expected results never arrived", line_sb.expected_lines.size());
      line_sb.errors++;
    end
    $display("covered %0d requests, %0d results checked, %0d bits handed over",
             requests_sent, line_sb.checked, line_sb.bits_sent);
    $display("%0d pushes dropped bits on a full buffer, %0d flushes",
             line_sb.drops, line_sb.flushes);
    if (line_sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
design/hbt_pkg.sv
design/hbt_ram.sv
design/handshake_bit_transmitter.sv
sim/tb_handshake_bit_transmitter.sv
